### rtl/lcd_i2c_nibble_serializer_unit_assert.svh
// Assertion macros for the LCD I2C nibble serialiser.
// Needs a clock named clk and a synchronous reset named rst in the including module.
// Concurrent checks are left out of synthesis, where the macros expand to nothing.
`ifndef LCD_I2C_NIBBLE_SERIALIZER_UNIT_ASSERT_SVH
`define LCD_I2C_NIBBLE_SERIALIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define LINS_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent that is followed in the next cycle by the consequent.
`define LINS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LINS_ASSERT(label, cond, msg)
`define LINS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### rtl/lins_pkg.sv
// Shared types and constants for the LCD I2C nibble serialiser.
// Has no dependencies; the top level imports it.
package lins_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned CfgDataWidth  = 7;
  localparam logic [CfgIndexWidth-1:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CfgIndexWidth-1:0] REG_BACKLIGHT_ON   = 1'b1;

  // Reset values of the configuration registers
  localparam logic [6:0] ADDR_RESET      = 7'h27;
  localparam logic       BACKLIGHT_RESET = 1'b1;

  // Expander port byte layout
  localparam logic [7:0] PORT_ENABLE = 8'h04;

  // Byte and bit positions within one transfer
  localparam logic [3:0] ACK_SLOT  = 4'd8;
  localparam logic [1:0] LAST_BYTE = 2'd3;

  // Bus symbol codes
  typedef enum logic [2:0] {
    SYM_START = 3'd0,
    SYM_ZERO  = 3'd1,
    SYM_ONE   = 3'd2,
    SYM_ACK   = 3'd3,
    SYM_STOP  = 3'd4
  } sym_t;

  // Symbol sequencer states
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_START,
    SEQ_BITS,
    SEQ_STOP
  } seq_state_t;

endpackage

### rtl/lcd_i2c_nibble_serializer_unit.sv
// Top level of the LCD I2C nibble serialiser: one nibble transfer in, 38 bus symbols out.
// Depends on lins_pkg and on lcd_i2c_nibble_serializer_unit_assert.svh.
//
//   channel   direction  contents
//   s_axis    in         tdata: nibble [3:0]; tuser: select_data
//   m_axis    out        tdata: bus_symbol [2:0]; tlast: symbol_last
//   cfg       in         write enable, register index, write data
//
// Each transaction on the input yields 38 output symbols, one per cycle while the
// output is taken; the symbol sequencer is the limit, so a new item is taken once the
// waiting one is loaded. One item waits in a holding register, loaded in idle or with the
// previous STOP; the first symbol passes the holding register and the START state.
// Reset clears the holding register, the sequencer and the output; back-pressure on
// the output stalls the sequencer without losing or repeating a symbol.
`include "lcd_i2c_nibble_serializer_unit_assert.svh"

module lcd_i2c_nibble_serializer_unit
  import lins_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // Input stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [3:0] nibble, [7:4] zero
  input  logic                     s_tuser,   // [0] select_data
  // Output stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,   // [2:0] bus_symbol, [7:3] zero
  output logic                     m_tlast,
  // Configuration write port
  input  logic                     cfg_write,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  // Configuration registers
  logic [6:0] device_address;
  logic       backlight_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
      backlight_on   <= BACKLIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        REG_BACKLIGHT_ON:   backlight_on   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Holding register for the next transaction
  logic       pend_valid;
  logic [3:0] pend_nibble;
  logic       pend_select;
  logic       load;
  logic       s_accept;

  assign s_tready = !pend_valid;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_accept) begin
      pend_valid <= 1'b1;
    end else if (load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      pend_nibble <= s_tdata[3:0];
      pend_select <= s_tuser;
    end
  end

  // Bytes of the transfer in progress
  logic [7:0] addr_byte;
  logic [7:0] port_byte;

  always_ff @(posedge clk) begin
    if (load) begin
      addr_byte <= {device_address, 1'b0};
      port_byte <= {pend_nibble, backlight_on, 2'b00, pend_select};
    end
  end

  // Sequencer registers
  seq_state_t seq_state, seq_next;
  logic [3:0] bit_idx, bit_next;
  logic [1:0] byte_idx, byte_next;
  logic       adv;
  logic       emit;
  sym_t       emit_sym;
  logic       emit_last;
  logic [7:0] cur_byte;

  // The output register is free when empty or when its symbol is taken now
  assign adv = !m_tvalid || m_tready;

  always_comb begin
    unique case (byte_idx)
      2'd0:    cur_byte = addr_byte;
      2'd2:    cur_byte = port_byte | PORT_ENABLE;
      default: cur_byte = port_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= SEQ_IDLE;
      bit_idx   <= '0;
      byte_idx  <= '0;
    end else begin
      seq_state <= seq_next;
      bit_idx   <= bit_next;
      byte_idx  <= byte_next;
    end
  end

  // Next state and symbol selection
  always_comb begin
    seq_next  = seq_state;
    bit_next  = bit_idx;
    byte_next = byte_idx;
    emit      = 1'b0;
    emit_sym  = SYM_START;
    emit_last = 1'b0;
    load      = 1'b0;
    unique case (seq_state)
      SEQ_IDLE: begin
        if (pend_valid) begin
          load     = 1'b1;
          seq_next = SEQ_START;
        end
      end
      SEQ_START: begin
        if (adv) begin
          emit      = 1'b1;
          emit_sym  = SYM_START;
          seq_next  = SEQ_BITS;
          bit_next  = '0;
          byte_next = '0;
        end
      end
      SEQ_BITS: begin
        if (adv) begin
          emit = 1'b1;
          if (bit_idx == ACK_SLOT) begin
            emit_sym = SYM_ACK;
            bit_next = '0;
            if (byte_idx == LAST_BYTE) begin
              seq_next = SEQ_STOP;
            end else begin
              byte_next = byte_idx + 2'd1;
            end
          end else begin
            // MSB first: bit 7 - bit_idx
            emit_sym = cur_byte[~bit_idx[2:0]] ? SYM_ONE : SYM_ZERO;
            bit_next = bit_idx + 4'd1;
          end
        end
      end
      SEQ_STOP: begin
        if (adv) begin
          emit      = 1'b1;
          emit_sym  = SYM_STOP;
          emit_last = 1'b1;
          if (pend_valid) begin
            load     = 1'b1;
            seq_next = SEQ_START;
          end else begin
            seq_next = SEQ_IDLE;
          end
        end
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  // Output register
  sym_t out_sym;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_sym <= emit_sym;
      m_tlast <= emit_last;
    end
  end

  assign m_tdata = {5'b00000, out_sym};

  // Checks on the sequencer and the output register
  `LINS_ASSERT(a_last_only_on_stop, !m_tvalid || (m_tlast == (out_sym == SYM_STOP)),
    "tlast does not match the STOP symbol")
  `LINS_ASSERT(a_bit_index_range, seq_state != SEQ_BITS || bit_idx <= ACK_SLOT,
    "bit index ran past the acknowledge slot")
  `LINS_ASSERT_NEXT(a_stop_then_last, seq_state == SEQ_STOP && adv, m_tvalid && m_tlast,
    "STOP was not placed in the output register")
  `LINS_ASSERT_NEXT(a_idle_loads, seq_state == SEQ_IDLE && pend_valid,
    seq_state == SEQ_START && !pend_valid, "waiting transaction was not loaded")

endmodule
